### design/gbfs_pkg.sv
package gbfs_pkg;

    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 32;

    localparam int CMD_W     = 2;
    localparam int ROW_IN_W  = 5;
    localparam int COL_IN_W  = 6;
    localparam int CELL_W    = 3;
    localparam int TAKEN_W   = 12;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 7;
    localparam int COLS_W    = 7;
    localparam int ROWS_W    = 6;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [CELL_W-1:0] CODE_WALL    = 3'd0;
    localparam logic [CELL_W-1:0] CODE_PATH    = 3'd1;
    localparam logic [CELL_W-1:0] CODE_VISITED = 3'd2;
    localparam logic [CELL_W-1:0] CODE_END     = 3'd4;

    localparam logic RES_SEARCH = 1'b0;
    localparam logic RES_READ   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd1;

    localparam logic [COLS_W-1:0] COLS_RESET = 7'd61;
    localparam logic [ROWS_W-1:0] ROWS_RESET = 6'd21;

    localparam logic [TAKEN_W-1:0] TAKEN_SAT = 12'd4095;

endpackage

### design/gbfs_ram.sv
module gbfs_ram #(
    parameter int DATA_W = 3,
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### design/grid_bfs_path_search.sv
// Breadth-first path search over a 4-neighbour grid of cells.
// Input channel s_*: one transaction per command. cmd load writes one cell
// code, cmd read returns one cell code, cmd search runs a search from the
// given start cell; cmd 3 is dropped. Result channel m_*: one transaction
// per search or read, result_kind telling which.
// Config channel cfg_*: index 0 sets the searched columns, index 1 the
// searched rows; always ready, to be written only while the block is idle.
// A load is written to the cell memory as it is accepted. A read passes
// through the memory read register, the pending value register and the
// output register. A search takes the cells from the coordinate queue in
// turn and reads each neighbour inside the area through the single read
// port of the cell memory. s_ready is low while a command is being
// worked on. After reset all 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) cells
// (2048 by default) of the cell memory are swept to wall, one cell per
// cycle; s_ready stays low during the sweep.
// A result waits in the output register while m_ready is low; the block
// holds the next result until the register is free.
module grid_bfs_path_search
    import gbfs_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CMD_W-1:0]     s_cmd,
    input  logic [ROW_IN_W-1:0]  s_row,
    input  logic [COL_IN_W-1:0]  s_col,
    input  logic [CELL_W-1:0]    s_cell_code,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_result_kind,
    output logic                 m_end_found,
    output logic [TAKEN_W-1:0]   m_cells_taken,
    output logic [CELL_W-1:0]    m_cell_value,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int CNT_W  = ADDR_W + 1;
    localparam int LC_W   = $clog2(MAX_COLS + 1);
    localparam int LR_W   = $clog2(MAX_ROWS + 1);
    localparam int CC_W   = (LC_W > COL_IN_W + 1) ? LC_W : COL_IN_W + 1;
    localparam int CR_W   = (LR_W > ROW_IN_W + 1) ? LR_W : ROW_IN_W + 1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_POP,
        ST_LATCH,
        ST_NREAD,
        ST_NCHECK,
        ST_RESULT
    } state_t;

    typedef enum logic [1:0] {
        DIR_UP,
        DIR_RIGHT,
        DIR_DOWN,
        DIR_LEFT
    } dir_t;

    state_t              state_reg, state_next;
    dir_t                dir_reg, dir_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [ROW_W-1:0]    r_reg, r_next;
    logic [COL_W-1:0]    c_reg, c_next;
    logic [ADDR_W-1:0]   nb_reg, nb_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [ADDR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TAKEN_W-1:0]  taken_reg, taken_next;
    logic                pend_kind_reg, pend_kind_next;
    logic                pend_found_reg, pend_found_next;
    logic                inside_reg, inside_next;
    logic [CELL_W-1:0]   pend_value_reg, pend_value_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_kind_reg, m_kind_next;
    logic                m_found_reg, m_found_next;
    logic [TAKEN_W-1:0]  m_taken_reg, m_taken_next;
    logic [CELL_W-1:0]   m_value_reg, m_value_next;
    logic [COLS_W-1:0]   cfg_cols_reg;
    logic [ROWS_W-1:0]   cfg_rows_reg;

    logic                cell_we, cell_re;
    logic [ADDR_W-1:0]   cell_waddr, cell_raddr;
    logic [CELL_W-1:0]   cell_wdata, cell_rdata;
    logic                fifo_we, fifo_re;
    logic [ADDR_W-1:0]   fifo_waddr, fifo_rdata;

    logic [LC_W-1:0]     lim_c;
    logic [LR_W-1:0]     lim_r;
    logic                s_accept, in_store, start_ok, out_free;
    logic [ADDR_W-1:0]   s_addr;
    logic                nb_ok;
    logic [ROW_W-1:0]    nr;
    logic [COL_W-1:0]    nc;

    function automatic logic [ADDR_W-1:0] nb_we_data(
        input logic              from_start,
        input logic [ADDR_W-1:0] start_addr,
        input logic [ADDR_W-1:0] nb_addr
    );
        return from_start ? start_addr : nb_addr;
    endfunction

    // clamp the configured area to the grid size
    always_comb begin
        if (CC_W'(cfg_cols_reg) > CC_W'(MAX_COLS)) begin
            lim_c = LC_W'(MAX_COLS);
        end else begin
            lim_c = LC_W'(cfg_cols_reg);
        end
        if (CR_W'(cfg_rows_reg) > CR_W'(MAX_ROWS)) begin
            lim_r = LR_W'(MAX_ROWS);
        end else begin
            lim_r = LR_W'(cfg_rows_reg);
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign in_store = (CR_W'(s_row) < CR_W'(MAX_ROWS)) && (CC_W'(s_col) < CC_W'(MAX_COLS));
    assign start_ok = (CR_W'(s_row) < CR_W'(lim_r)) && (CC_W'(s_col) < CC_W'(lim_c));
    assign s_addr   = {ROW_W'(s_row), COL_W'(s_col)};

    // neighbour of the current cell in the current direction
    always_comb begin
        nr    = r_reg;
        nc    = c_reg;
        nb_ok = 1'b0;
        case (dir_reg)
            DIR_UP: begin
                nb_ok = (r_reg != '0);
                nr    = r_reg - ROW_W'(1);
            end
            DIR_RIGHT: begin
                nb_ok = (LC_W'(c_reg) + LC_W'(1)) < lim_c;
                nc    = c_reg + COL_W'(1);
            end
            DIR_DOWN: begin
                nb_ok = (LR_W'(r_reg) + LR_W'(1)) < lim_r;
                nr    = r_reg + ROW_W'(1);
            end
            DIR_LEFT: begin
                nb_ok = (c_reg != '0);
                nc    = c_reg - COL_W'(1);
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        dir_next        = dir_reg;
        clr_next        = clr_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        nb_next         = nb_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        taken_next      = taken_reg;
        pend_kind_next  = pend_kind_reg;
        pend_found_next = pend_found_reg;
        pend_value_next = pend_value_reg;
        inside_next     = inside_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_kind_next     = m_kind_reg;
        m_found_next    = m_found_reg;
        m_taken_next    = m_taken_reg;
        m_value_next    = m_value_reg;

        cell_we    = 1'b0;
        cell_waddr = s_addr;
        cell_wdata = s_cell_code;
        cell_re    = 1'b0;
        cell_raddr = s_addr;
        fifo_we    = 1'b0;
        fifo_waddr = tail_reg;
        fifo_re    = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                cell_we    = 1'b1;
                cell_waddr = clr_reg;
                cell_wdata = CODE_WALL;
                clr_next   = clr_reg + ADDR_W'(1);
                if (clr_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_cmd)
                        CMD_LOAD: begin
                            cell_we = in_store;
                        end
                        CMD_READ: begin
                            cell_re        = in_store;
                            inside_next    = in_store;
                            pend_kind_next = RES_READ;
                            state_next     = ST_RD_WAIT;
                        end
                        CMD_SEARCH: begin
                            pend_kind_next  = RES_SEARCH;
                            pend_found_next = 1'b0;
                            taken_next      = '0;
                            head_next       = '0;
                            if (start_ok) begin
                                cell_we    = 1'b1;
                                cell_wdata = CODE_VISITED;
                                fifo_we    = 1'b1;
                                fifo_waddr = '0;
                                tail_next  = ADDR_W'(1);
                                count_next = CNT_W'(1);
                                state_next = ST_POP;
                            end else begin
                                tail_next  = '0;
                                count_next = '0;
                                state_next = ST_RESULT;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RD_WAIT: begin
                pend_value_next = inside_reg ? cell_rdata : CODE_WALL;
                state_next      = ST_RESULT;
            end
            ST_POP: begin
                if (count_reg == '0) begin
                    state_next = ST_RESULT;
                end else begin
                    fifo_re    = 1'b1;
                    head_next  = head_reg + ADDR_W'(1);
                    count_next = count_reg - CNT_W'(1);
                    if (taken_reg != TAKEN_SAT) begin
                        taken_next = taken_reg + TAKEN_W'(1);
                    end
                    state_next = ST_LATCH;
                end
            end
            ST_LATCH: begin
                r_next     = fifo_rdata[ADDR_W-1:COL_W];
                c_next     = fifo_rdata[COL_W-1:0];
                dir_next   = DIR_UP;
                state_next = ST_NREAD;
            end
            ST_NREAD: begin
                if (nb_ok) begin
                    cell_re    = 1'b1;
                    cell_raddr = {nr, nc};
                    nb_next    = {nr, nc};
                    state_next = ST_NCHECK;
                end else if (dir_reg == DIR_LEFT) begin
                    state_next = ST_POP;
                end else begin
                    dir_next = dir_t'(dir_reg + 2'd1);
                end
            end
            ST_NCHECK: begin
                if (cell_rdata == CODE_END) begin
                    pend_found_next = 1'b1;
                    state_next      = ST_RESULT;
                end else begin
                    if (cell_rdata == CODE_PATH) begin
                        cell_we    = 1'b1;
                        cell_waddr = nb_reg;
                        cell_wdata = CODE_VISITED;
                        fifo_we    = 1'b1;
                        tail_next  = tail_reg + ADDR_W'(1);
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (dir_reg == DIR_LEFT) begin
                        state_next = ST_POP;
                    end else begin
                        dir_next   = dir_t'(dir_reg + 2'd1);
                        state_next = ST_NREAD;
                    end
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = pend_kind_reg;
                    if (pend_kind_reg == RES_READ) begin
                        m_found_next = 1'b0;
                        m_taken_next = '0;
                        m_value_next = pend_value_reg;
                    end else begin
                        m_found_next = pend_found_reg;
                        m_taken_next = taken_reg;
                        m_value_next = CODE_WALL;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            taken_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            taken_reg   <= taken_next;
            m_valid_reg <= m_valid_next;
        end
        dir_reg        <= dir_next;
        r_reg          <= r_next;
        c_reg          <= c_next;
        nb_reg         <= nb_next;
        pend_kind_reg  <= pend_kind_next;
        pend_found_reg <= pend_found_next;
        pend_value_reg <= pend_value_next;
        inside_reg     <= inside_next;
        m_kind_reg     <= m_kind_next;
        m_found_reg    <= m_found_next;
        m_taken_reg    <= m_taken_next;
        m_value_reg    <= m_value_next;
    end

    // configuration transactions
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_cols_reg <= COLS_RESET;
            cfg_rows_reg <= ROWS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_COLS: cfg_cols_reg <= cfg_data;
                REG_ROWS: cfg_rows_reg <= cfg_data[ROWS_W-1:0];
                default: begin
                    cfg_cols_reg <= cfg_cols_reg;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_kind = m_kind_reg;
    assign m_end_found   = m_found_reg;
    assign m_cells_taken = m_taken_reg;
    assign m_cell_value  = m_value_reg;

    gbfs_ram #(
        .DATA_W (CELL_W),
        .ADDR_W (ADDR_W)
    ) u_cell_ram (
        .aclk  (aclk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .re    (cell_re),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    // coordinate queue, entries are {row, col}
    gbfs_ram #(
        .DATA_W (ADDR_W),
        .ADDR_W (ADDR_W)
    ) u_coord_ram (
        .aclk  (aclk),
        .we    (fifo_we),
        .waddr (fifo_waddr),
        .wdata (nb_we_data(state_reg == ST_IDLE, s_addr, nb_reg)),
        .re    (fifo_re),
        .raddr (head_reg),
        .rdata (fifo_rdata)
    );

endmodule

### tb/bfs_result_checker.sv
`timescale 1ns / 100ps

module bfs_result_checker
    import gbfs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [CMD_W-1:0]     s_cmd,
    input  logic [ROW_IN_W-1:0]  s_row,
    input  logic [COL_IN_W-1:0]  s_col,
    input  logic [CELL_W-1:0]    s_cell_code,

    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_result_kind,
    input  logic                 m_end_found,
    input  logic [TAKEN_W-1:0]   m_cells_taken,
    input  logic [CELL_W-1:0]    m_cell_value,

    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    output int                   mismatches,
    output int                   awaiting
);

    localparam int GRID_CELLS = MAX_ROWS_DEF * MAX_COLS_DEF;

    typedef struct packed {
        logic               kind;
        logic               found;
        logic [TAKEN_W-1:0] taken;
        logic [CELL_W-1:0]  value;
    } answer_t;

    logic [CELL_W-1:0] grid_codes [GRID_CELLS];
    logic [COLS_W-1:0] cols_reg;
    logic [ROWS_W-1:0] rows_reg;
    answer_t           awaited_answers [$];

    // breadth-first walk over the local grid copy, marking cells as they are queued
    function automatic answer_t search_grid(input int start_r, input int start_c);
        int      dr [4] = '{-1, 0, 1, 0};
        int      dc [4] = '{0, 1, 0, -1};
        int      frontier [$];
        int      lim_r;
        int      lim_c;
        int      cur;
        int      nr;
        int      nc;
        int      nxt;
        int      taken;
        logic    hit;
        answer_t ans;
        lim_c = (cols_reg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_reg);
        lim_r = (rows_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_reg);
        hit   = 1'b0;
        taken = 0;
        if (start_r < lim_r && start_c < lim_c) begin
            grid_codes[start_r * MAX_COLS_DEF + start_c] = CODE_VISITED;
            frontier.push_back(start_r * MAX_COLS_DEF + start_c);
        end
        while (frontier.size() != 0 && !hit) begin
            cur = frontier.pop_front();
            if (taken < TAKEN_SAT)
                taken++;
            for (int d = 0; d < 4 && !hit; d++) begin
                nr = cur / MAX_COLS_DEF + dr[d];
                nc = cur % MAX_COLS_DEF + dc[d];
                if (nr >= 0 && nc >= 0 && nr < lim_r && nc < lim_c) begin
                    nxt = nr * MAX_COLS_DEF + nc;
                    if (grid_codes[nxt] == CODE_PATH) begin
                        grid_codes[nxt] = CODE_VISITED;
                        frontier.push_back(nxt);
                    end else if (grid_codes[nxt] == CODE_END) begin
                        hit = 1'b1;
                    end
                end
            end
        end
        ans.kind  = RES_SEARCH;
        ans.found = hit;
        ans.taken = TAKEN_W'(taken);
        ans.value = CODE_WALL;
        return ans;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        int      idx;
        if (!aresetn) begin
            foreach (grid_codes[i])
                grid_codes[i] = CODE_WALL;
            cols_reg = COLS_RESET;
            rows_reg = ROWS_RESET;
            awaited_answers.delete();
            mismatches = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_COLS)
                    cols_reg = cfg_data[COLS_W-1:0];
                else if (cfg_index == REG_ROWS)
                    rows_reg = cfg_data[ROWS_W-1:0];
            end
            if (m_valid && m_ready) begin
                if (awaited_answers.size() == 0) begin
                    $display({"%0t: result transaction with none expected, ",
                              "got kind %0d found %0d taken %0d value %0d"},
                             $time, m_result_kind, m_end_found, m_cells_taken, m_cell_value);
                    mismatches++;
                end else begin
                    want = awaited_answers.pop_front();
                    check_field("result_kind", want.kind, m_result_kind);
                    check_field("end_found", want.found, m_end_found);
                    check_field("cells_taken", want.taken, m_cells_taken);
                    check_field("cell_value", want.value, m_cell_value);
                end
            end
            if (s_valid && s_ready) begin
                idx = s_row * MAX_COLS_DEF + s_col;
                case (s_cmd)
                    CMD_LOAD: begin
                        grid_codes[idx] = s_cell_code;
                    end
                    CMD_SEARCH: begin
                        awaited_answers.push_back(search_grid(s_row, s_col));
                    end
                    CMD_READ: begin
                        want.kind  = RES_READ;
                        want.found = 1'b0;
                        want.taken = '0;
                        want.value = grid_codes[idx];
                        awaited_answers.push_back(want);
                    end
                    default: begin
                    end
                endcase
            end
        end
        awaiting = awaited_answers.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import gbfs_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_IGNORED   = 2'd3;
    localparam logic [CELL_W-1:0] CODE_START    = 3'd3;
    localparam int                ITEM_TARGET   = 1850;
    localparam int                CYCLE_LIMIT   = 2_000_000;
    localparam int                IDLE_PCT      = 10;
    localparam int                SETTLE_CYCLES = 12;

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;

    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_cmd         = CMD_LOAD;
    logic [ROW_IN_W-1:0]  s_row         = '0;
    logic [COL_IN_W-1:0]  s_col         = '0;
    logic [CELL_W-1:0]    s_cell_code   = CODE_WALL;

    logic                 m_valid;
    logic                 m_ready       = 1'b1;
    logic                 m_result_kind;
    logic                 m_end_found;
    logic [TAKEN_W-1:0]   m_cells_taken;
    logic [CELL_W-1:0]    m_cell_value;

    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = REG_COLS;
    logic [CFG_W-1:0]     cfg_data      = '0;

    int                   mismatches;
    int                   awaiting;
    int                   cycle_count   = 0;
    int                   items_sent    = 0;
    logic                 steady        = 1'b0;

    grid_bfs_path_search dut (.*);

    bfs_result_checker checker_inst (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk)
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** grid_bfs_path_search: FAILED **");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ROW_IN_W-1:0] row,
                             input logic [COL_IN_W-1:0] col, input logic [CELL_W-1:0] code);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= cmd;
        s_row       <= row;
        s_col       <= col;
        s_cell_code <= code;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (cmd != CMD_IGNORED)
            items_sent++;
    endtask

    // loads give no result, so keep waiting a while once nothing is outstanding
    task automatic settle();
        s_valid <= 1'b0;
        while (awaiting != 0 || !s_ready)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_area(input logic [CFG_W-1:0] cols_val, input logic [CFG_W-1:0] rows_val);
        cfg_valid <= 1'b1;
        cfg_index <= REG_COLS;
        cfg_data  <= cols_val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_index <= REG_ROWS;
        cfg_data  <= rows_val;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int                  lim_r;
        int                  lim_c;
        int                  wr;
        int                  wc;
        int                  r_base;
        int                  c_base;
        int                  roll;
        logic [CFG_W-1:0]    cols_val;
        logic [CFG_W-1:0]    rows_val;
        logic [CELL_W-1:0]   code;
        logic [ROW_IN_W-1:0] row;
        logic [COL_IN_W-1:0] col;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        settle();

        // far corner straight after the sweep
        send_item(CMD_READ, '1, '1, CODE_WALL);

        settle();
        set_area(7'd3, 7'd2);
        send_item(CMD_LOAD, 5'd0, 6'd1, CODE_PATH);
        send_item(CMD_LOAD, 5'd0, 6'd2, CODE_END);
        send_item(CMD_LOAD, 5'd1, 6'd0, CODE_PATH);
        send_item(CMD_LOAD, 5'd1, 6'd1, CODE_END + 3'd3);
        send_item(CMD_LOAD, 5'd1, 6'd2, CODE_PATH);
        // wall start is still queued
        send_item(CMD_SEARCH, 5'd0, 6'd0, CODE_WALL);
        send_item(CMD_READ, 5'd0, 6'd0, CODE_WALL);
        send_item(CMD_READ, 5'd1, 6'd1, CODE_WALL);
        send_item(CMD_SEARCH, 5'd1, 6'd2, CODE_WALL);
        // end code on the start cell does not count
        send_item(CMD_SEARCH, 5'd0, 6'd2, CODE_WALL);
        // start just past the last column
        send_item(CMD_SEARCH, 5'd0, 6'd3, CODE_WALL);
        send_item(CMD_LOAD, '1, '1, CODE_START);
        send_item(CMD_READ, '1, '1, CODE_WALL);
        send_item(CMD_LOAD, 5'd31, 6'd62, CODE_END + 3'd2);
        send_item(CMD_READ, 5'd31, 6'd62, CODE_WALL);
        send_item(CMD_IGNORED, '1, '1, '1);

        settle();
        set_area(7'd0, 7'd32);
        send_item(CMD_SEARCH, 5'd0, 6'd0, CODE_WALL);

        // columns clamp to the grid width, top bit of the rows value is dropped
        settle();
        set_area(7'd127, 7'h45);
        send_item(CMD_LOAD, 5'd0, 6'd63, CODE_PATH);
        send_item(CMD_LOAD, 5'd1, 6'd63, CODE_END);
        send_item(CMD_SEARCH, 5'd0, 6'd62, CODE_WALL);

        settle();
        set_area(7'd64, 7'd63);
        send_item(CMD_LOAD, 5'd31, 6'd0, CODE_PATH);
        send_item(CMD_SEARCH, 5'd30, 6'd0, CODE_WALL);

        settle();
        set_area(7'd1, 7'd0);
        send_item(CMD_SEARCH, 5'd0, 6'd0, CODE_WALL);

        while (items_sent < ITEM_TARGET) begin
            settle();
            steady <= (items_sent >= 700 && items_sent < 1000);

            case ($urandom_range(0, 7))
                0:       cols_val = CFG_W'($urandom_range(64, 127));
                1:       cols_val = 7'd64;
                2:       cols_val = CFG_W'($urandom_range(0, 1));
                default: cols_val = CFG_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 7))
                0:       rows_val = CFG_W'($urandom_range(0, 127));
                1:       rows_val = 7'd32;
                2:       rows_val = CFG_W'($urandom_range(0, 1));
                default: rows_val = CFG_W'($urandom_range(1, 8));
            endcase
            set_area(cols_val, rows_val);
            lim_c = (cols_val > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_val);
            lim_r = (rows_val[ROWS_W-1:0] > MAX_ROWS_DEF) ? MAX_ROWS_DEF
                                                          : int'(rows_val[ROWS_W-1:0]);

            // a small maze window somewhere inside the searched area
            wr = (lim_r < 8) ? lim_r : $urandom_range(1, 8);
            wc = (lim_c < 12) ? lim_c : $urandom_range(1, 12);
            r_base = (lim_r > wr) ? $urandom_range(0, lim_r - wr) : 0;
            c_base = (lim_c > wc) ? $urandom_range(0, lim_c - wc) : 0;

            for (int r = 0; r < wr; r++) begin
                for (int c = 0; c < wc; c++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 55)
                        code = CODE_PATH;
                    else if (roll < 78)
                        code = CODE_WALL;
                    else if (roll < 88)
                        code = CODE_END;
                    else if (roll < 92)
                        code = CODE_VISITED;
                    else if (roll < 95)
                        code = CODE_START;
                    else
                        code = CODE_END + CELL_W'($urandom_range(1, 3));
                    send_item(CMD_LOAD, ROW_IN_W'(r_base + r), COL_IN_W'(c_base + c), code);
                end
            end

            repeat ($urandom_range(1, 3)) begin
                if (wr > 0 && wc > 0 && $urandom_range(0, 99) < 80) begin
                    row = ROW_IN_W'(r_base + $urandom_range(0, wr - 1));
                    col = COL_IN_W'(c_base + $urandom_range(0, wc - 1));
                end else begin
                    row = ROW_IN_W'($urandom_range(0, 31));
                    col = COL_IN_W'($urandom_range(0, 63));
                end
                send_item(CMD_SEARCH, row, col, CELL_W'($urandom_range(0, 7)));
            end

            // read back the visited marks
            repeat ($urandom_range(2, 6)) begin
                if (wr > 0 && wc > 0 && $urandom_range(0, 99) < 80) begin
                    row = ROW_IN_W'(r_base + $urandom_range(0, wr - 1));
                    col = COL_IN_W'(c_base + $urandom_range(0, wc - 1));
                end else begin
                    row = ROW_IN_W'($urandom_range(0, 31));
                    col = COL_IN_W'($urandom_range(0, 63));
                end
                send_item(CMD_READ, row, col, CELL_W'($urandom_range(0, 7)));
            end

            repeat ($urandom_range(0, 2))
                send_item(CMD_W'($urandom_range(0, 3)), ROW_IN_W'($urandom_range(0, 31)),
                          COL_IN_W'($urandom_range(0, 63)), CELL_W'($urandom_range(0, 7)));
        end

        settle();
        if (mismatches == 0 && awaiting == 0)
            $display("** grid_bfs_path_search: PASSED **");
        else
            $display("** grid_bfs_path_search: FAILED **");
        $finish;
    end

endmodule
